/* rtl/char_reference_decoder_assert.svh */
// assertion macros for the character reference decoder
`ifndef CHAR_REFERENCE_DECODER_ASSERT_SVH
`define CHAR_REFERENCE_DECODER_ASSERT_SVH

// same-cycle implication
`define CHRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/chrd_pkg.sv */
// shared types, constants and name table of the character reference decoder
package chrd_pkg;

    localparam int KEY_BYTES   = 24;
    localparam int KEY_W       = KEY_BYTES * 8;
    localparam int ROM_ENTRIES = 247;
    localparam int ROM_IDX_W   = $clog2(ROM_ENTRIES);
    localparam int CODE_W      = 24;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    localparam logic [KEY_W-1:0] NGE_KEY = KEY_W'("ngE");

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_CODE = 2'd1,
        CMD_NGE  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [CODE_W-1:0]  data;
        logic               last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [20:0]      point;
    } t_rom_entry;

    localparam t_rom_entry NAME_ROM [ROM_ENTRIES] = '{
        '{KEY_W'("AElig"),21'hC6}, '{KEY_W'("AMP"),21'h26}, '{KEY_W'("Aacute"),21'hC1},
        '{KEY_W'("Acirc"),21'hC2}, '{KEY_W'("Agrave"),21'hC0}, '{KEY_W'("Alpha"),21'h391},
        '{KEY_W'("Aring"),21'hC5}, '{KEY_W'("Atilde"),21'hC3}, '{KEY_W'("Auml"),21'hC4},
        '{KEY_W'("Beta"),21'h392}, '{KEY_W'("COPY"),21'hA9}, '{KEY_W'("Ccedil"),21'hC7},
        '{KEY_W'("Chi"),21'h3A7}, '{KEY_W'("ClockwiseContourIntegral"),21'h2232},
        '{KEY_W'("Dagger"),21'h2021}, '{KEY_W'("Dcaron"),21'h10E},
        '{KEY_W'("Delta"),21'h394}, '{KEY_W'("DifferentialD"),21'h2146},
        '{KEY_W'("ETH"),21'hD0}, '{KEY_W'("Eacute"),21'hC9}, '{KEY_W'("Ecirc"),21'hCA},
        '{KEY_W'("Egrave"),21'hC8}, '{KEY_W'("Epsilon"),21'h395}, '{KEY_W'("Eta"),21'h397},
        '{KEY_W'("Euml"),21'hCB}, '{KEY_W'("GT"),21'h3E}, '{KEY_W'("Gamma"),21'h393},
        '{KEY_W'("HilbertSpace"),21'h210B}, '{KEY_W'("Iacute"),21'hCD},
        '{KEY_W'("Icirc"),21'hCE}, '{KEY_W'("Igrave"),21'hCC}, '{KEY_W'("Iota"),21'h399},
        '{KEY_W'("Iuml"),21'hCF}, '{KEY_W'("Kappa"),21'h39A}, '{KEY_W'("LT"),21'h3C},
        '{KEY_W'("Lambda"),21'h39B}, '{KEY_W'("Mu"),21'h39C}, '{KEY_W'("Nu"),21'h39D},
        '{KEY_W'("Oacute"),21'hD3}, '{KEY_W'("Ocirc"),21'hD4}, '{KEY_W'("OElig"),21'h152},
        '{KEY_W'("Ograve"),21'hD2}, '{KEY_W'("Omega"),21'h3A9},
        '{KEY_W'("Omicron"),21'h39F}, '{KEY_W'("Otilde"),21'hD5}, '{KEY_W'("Ouml"),21'hD6},
        '{KEY_W'("Pi"),21'h3A0}, '{KEY_W'("Prime"),21'h2033}, '{KEY_W'("Psi"),21'h3A8},
        '{KEY_W'("QUOT"),21'h22}, '{KEY_W'("REG"),21'hAE}, '{KEY_W'("Rho"),21'h3A1},
        '{KEY_W'("Scaron"),21'h160}, '{KEY_W'("Sigma"),21'h3A3}, '{KEY_W'("THORN"),21'hDE},
        '{KEY_W'("Tau"),21'h3A4}, '{KEY_W'("Theta"),21'h398}, '{KEY_W'("Uacute"),21'hDA},
        '{KEY_W'("Ucirc"),21'hDB}, '{KEY_W'("Ugrave"),21'hD9}, '{KEY_W'("Upsilon"),21'h3A5},
        '{KEY_W'("Uuml"),21'hDC}, '{KEY_W'("Xi"),21'h39E}, '{KEY_W'("Yacute"),21'hDD},
        '{KEY_W'("Yuml"),21'h178}, '{KEY_W'("Zeta"),21'h396},
        '{KEY_W'("aacute"),21'hE1}, '{KEY_W'("acirc"),21'hE2}, '{KEY_W'("acute"),21'hB4},
        '{KEY_W'("aelig"),21'hE6}, '{KEY_W'("agrave"),21'hE0},
        '{KEY_W'("alefsym"),21'h2135}, '{KEY_W'("alpha"),21'h3B1}, '{KEY_W'("amp"),21'h26},
        '{KEY_W'("and"),21'h2227}, '{KEY_W'("ang"),21'h2220}, '{KEY_W'("apos"),21'h27},
        '{KEY_W'("aring"),21'hE5}, '{KEY_W'("asymp"),21'h2248}, '{KEY_W'("atilde"),21'hE3},
        '{KEY_W'("auml"),21'hE4}, '{KEY_W'("bdquo"),21'h201E}, '{KEY_W'("beta"),21'h3B2},
        '{KEY_W'("brvbar"),21'hA6}, '{KEY_W'("bull"),21'h2022}, '{KEY_W'("cap"),21'h2229},
        '{KEY_W'("ccedil"),21'hE7}, '{KEY_W'("cedil"),21'hB8}, '{KEY_W'("cent"),21'hA2},
        '{KEY_W'("chi"),21'h3C7}, '{KEY_W'("circ"),21'h2C6}, '{KEY_W'("clubs"),21'h2663},
        '{KEY_W'("cong"),21'h2245}, '{KEY_W'("copy"),21'hA9}, '{KEY_W'("crarr"),21'h21B5},
        '{KEY_W'("cup"),21'h222A}, '{KEY_W'("curren"),21'hA4}, '{KEY_W'("dagger"),21'h2020},
        '{KEY_W'("darr"),21'h2193}, '{KEY_W'("deg"),21'hB0}, '{KEY_W'("delta"),21'h3B4},
        '{KEY_W'("diams"),21'h2666}, '{KEY_W'("divide"),21'hF7}, '{KEY_W'("eacute"),21'hE9},
        '{KEY_W'("ecirc"),21'hEA}, '{KEY_W'("egrave"),21'hE8}, '{KEY_W'("emsp"),21'h2003},
        '{KEY_W'("empty"),21'h2205}, '{KEY_W'("ensp"),21'h2002},
        '{KEY_W'("epsilon"),21'h3B5}, '{KEY_W'("equiv"),21'h2261}, '{KEY_W'("eta"),21'h3B7},
        '{KEY_W'("eth"),21'hF0}, '{KEY_W'("euml"),21'hEB}, '{KEY_W'("exist"),21'h2203},
        '{KEY_W'("fnof"),21'h192}, '{KEY_W'("forall"),21'h2200}, '{KEY_W'("frac12"),21'hBD},
        '{KEY_W'("frac14"),21'hBC}, '{KEY_W'("frac34"),21'hBE}, '{KEY_W'("frasl"),21'h2044},
        '{KEY_W'("gamma"),21'h3B3}, '{KEY_W'("ge"),21'h2265}, '{KEY_W'("gt"),21'h3E},
        '{KEY_W'("hArr"),21'h21D4}, '{KEY_W'("harr"),21'h2194}, '{KEY_W'("hearts"),21'h2665},
        '{KEY_W'("hellip"),21'h2026}, '{KEY_W'("iacute"),21'hED}, '{KEY_W'("icirc"),21'hEE},
        '{KEY_W'("igrave"),21'hEC}, '{KEY_W'("image"),21'h2111}, '{KEY_W'("infin"),21'h221E},
        '{KEY_W'("int"),21'h222B}, '{KEY_W'("iota"),21'h3B9}, '{KEY_W'("iquest"),21'hBF},
        '{KEY_W'("iuml"),21'hEF}, '{KEY_W'("kappa"),21'h3BA}, '{KEY_W'("lArr"),21'h21D0},
        '{KEY_W'("lang"),21'h2329}, '{KEY_W'("laquo"),21'hAB}, '{KEY_W'("larr"),21'h2190},
        '{KEY_W'("lceil"),21'h2308}, '{KEY_W'("ldquo"),21'h201C}, '{KEY_W'("le"),21'h2264},
        '{KEY_W'("lfloor"),21'h230A}, '{KEY_W'("lowast"),21'h2217}, '{KEY_W'("loz"),21'h25CA},
        '{KEY_W'("lrm"),21'h200E}, '{KEY_W'("lsaquo"),21'h2039}, '{KEY_W'("lsquo"),21'h2018},
        '{KEY_W'("lt"),21'h3C}, '{KEY_W'("macr"),21'hAF}, '{KEY_W'("mdash"),21'h2014},
        '{KEY_W'("micro"),21'hB5}, '{KEY_W'("middot"),21'hB7}, '{KEY_W'("minus"),21'h2212},
        '{KEY_W'("mu"),21'h3BC}, '{KEY_W'("nabla"),21'h2207}, '{KEY_W'("nbsp"),21'hA0},
        '{KEY_W'("ndash"),21'h2013}, '{KEY_W'("ne"),21'h2260}, '{KEY_W'("ni"),21'h220B},
        '{KEY_W'("not"),21'hAC}, '{KEY_W'("notin"),21'h2209}, '{KEY_W'("nsub"),21'h2284},
        '{KEY_W'("ntilde"),21'hF1}, '{KEY_W'("nu"),21'h3BD}, '{KEY_W'("oacute"),21'hF3},
        '{KEY_W'("ocirc"),21'hF4}, '{KEY_W'("oelig"),21'h153}, '{KEY_W'("ograve"),21'hF2},
        '{KEY_W'("oline"),21'h203E}, '{KEY_W'("omega"),21'h3C9},
        '{KEY_W'("omicron"),21'h3BF}, '{KEY_W'("oplus"),21'h2295}, '{KEY_W'("or"),21'h2228},
        '{KEY_W'("ordf"),21'hAA}, '{KEY_W'("ordm"),21'hBA}, '{KEY_W'("oslash"),21'hF8},
        '{KEY_W'("otilde"),21'hF5}, '{KEY_W'("otimes"),21'h2297}, '{KEY_W'("ouml"),21'hF6},
        '{KEY_W'("para"),21'hB6}, '{KEY_W'("part"),21'h2202}, '{KEY_W'("permil"),21'h2030},
        '{KEY_W'("phi"),21'h3C6}, '{KEY_W'("pi"),21'h3C0}, '{KEY_W'("piv"),21'h3D6},
        '{KEY_W'("plusmn"),21'hB1}, '{KEY_W'("pound"),21'hA3}, '{KEY_W'("prime"),21'h2032},
        '{KEY_W'("prod"),21'h220F}, '{KEY_W'("prop"),21'h221D}, '{KEY_W'("psi"),21'h3C8},
        '{KEY_W'("quot"),21'h22}, '{KEY_W'("rArr"),21'h21D2}, '{KEY_W'("rang"),21'h232A},
        '{KEY_W'("raquo"),21'hBB}, '{KEY_W'("rarr"),21'h2192}, '{KEY_W'("rceil"),21'h2309},
        '{KEY_W'("rdquo"),21'h201D}, '{KEY_W'("real"),21'h211C}, '{KEY_W'("reg"),21'hAE},
        '{KEY_W'("rfloor"),21'h230B}, '{KEY_W'("rho"),21'h3C1}, '{KEY_W'("rlm"),21'h200F},
        '{KEY_W'("rsaquo"),21'h203A}, '{KEY_W'("rsquo"),21'h2019}, '{KEY_W'("sbquo"),21'h201A},
        '{KEY_W'("scaron"),21'h161}, '{KEY_W'("sdot"),21'h22C5}, '{KEY_W'("sect"),21'hA7},
        '{KEY_W'("shy"),21'hAD}, '{KEY_W'("sigma"),21'h3C3}, '{KEY_W'("sigmaf"),21'h3C2},
        '{KEY_W'("sim"),21'h223C}, '{KEY_W'("spades"),21'h2660}, '{KEY_W'("sub"),21'h2282},
        '{KEY_W'("sube"),21'h2286}, '{KEY_W'("sum"),21'h2211}, '{KEY_W'("sup"),21'h2283},
        '{KEY_W'("sup1"),21'hB9}, '{KEY_W'("sup2"),21'hB2}, '{KEY_W'("sup3"),21'hB3},
        '{KEY_W'("supe"),21'h2287}, '{KEY_W'("szlig"),21'hDF}, '{KEY_W'("tau"),21'h3C4},
        '{KEY_W'("there4"),21'h2234}, '{KEY_W'("theta"),21'h3B8},
        '{KEY_W'("thetasym"),21'h3D1}, '{KEY_W'("thinsp"),21'h2009},
        '{KEY_W'("thorn"),21'hFE}, '{KEY_W'("tilde"),21'h2DC}, '{KEY_W'("times"),21'hD7},
        '{KEY_W'("trade"),21'h2122}, '{KEY_W'("uArr"),21'h21D1}, '{KEY_W'("uarr"),21'h2191},
        '{KEY_W'("uml"),21'hA8}, '{KEY_W'("upsih"),21'h3D2}, '{KEY_W'("upsilon"),21'h3C5},
        '{KEY_W'("weierp"),21'h2118}, '{KEY_W'("xi"),21'h3BE}, '{KEY_W'("yen"),21'hA5},
        '{KEY_W'("yuml"),21'hFF}, '{KEY_W'("zwnj"),21'h200C}, '{KEY_W'("zwj"),21'h200D}
    };

endpackage

/* rtl/chrd_front.sv */
// front end: reference scanner, held bytes, name search and command issue
module chrd_front #(
    parameter int MAX_NAME_LEN   = 24,
    parameter int NAME_ROM_DEPTH = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_text_byte,
    input  logic                 i_end_of_text,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  chrd_pkg::t_fifo_stat i_fifo_stat,
    output logic                 o_push,
    output chrd_pkg::t_cmd       o_cmd
);
    import chrd_pkg::*;

    localparam int HELD_DEPTH = MAX_NAME_LEN + 1;
    localparam int CNT_W      = $clog2(HELD_DEPTH + 1);
    localparam int IDX_W      = $clog2(HELD_DEPTH);
    localparam int SEARCH_N   = (ROM_ENTRIES < NAME_ROM_DEPTH) ? ROM_ENTRIES : NAME_ROM_DEPTH;

    typedef enum logic [3:0] {
        F_IDLE   = 4'b0001,
        F_FLUSH  = 4'b0010,
        F_SEARCH = 4'b0100,
        F_PLAIN  = 4'b1000
    } t_fstate;

    typedef enum logic [4:0] {
        M_TEXT = 5'b00001,
        M_AMP  = 5'b00010,
        M_HASH = 5'b00100,
        M_NUM  = 5'b01000,
        M_NAME = 5'b10000
    } t_mode;

    function automatic logic is_name_char(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
               (b >= 8'h30 && b <= 8'h39) || b == 8'h5F || b == 8'h2D;
    endfunction

    function automatic logic [4:0] digit_value(input logic [7:0] b, input logic hex);
        logic [4:0] d;
        d = 5'd16;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = 5'(b - 8'h30);
        end else if (hex && b >= 8'h61 && b <= 8'h66) begin
            d = 5'(b - 8'h57);
        end else if (hex && b >= 8'h41 && b <= 8'h46) begin
            d = 5'(b - 8'h37);
        end
        return d;
    endfunction

    t_fstate            r_state, n_state;
    t_mode              r_mode, n_mode;
    logic [7:0]         r_held [HELD_DEPTH];
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CODE_W-1:0]  r_code, n_code;
    logic               r_hex, n_hex;
    logic [2:0]         r_dc, n_dc;
    logic [KEY_W-1:0]   r_name, n_name;
    logic [IDX_W-1:0]   r_fidx, n_fidx;
    logic [ROM_IDX_W-1:0] r_sidx, n_sidx;
    logic [7:0]         r_byte, n_byte;
    logic               r_eot, n_eot;
    logic               r_tail, n_tail;
    logic               r_tail_emits, n_tail_emits;

    logic               w_hwe;
    logic [IDX_W-1:0]   w_hidx;
    logic [7:0]         w_hdata;
    logic               w_accept;
    logic [4:0]         w_dig;
    logic               w_name_ok;
    logic               w_hit;
    logic               w_hold;
    logic               w_flush_last;
    logic [CODE_W-1:0]  w_code_x10;

    assign o_ready   = (r_state == F_IDLE) && !i_fifo_stat.full;
    assign w_accept  = i_valid && o_ready;
    assign w_dig     = digit_value(i_text_byte, r_hex);
    assign w_name_ok = (int'(r_cnt) - 1) <= KEY_BYTES;
    assign w_hit     = w_name_ok && (NAME_ROM[r_sidx].key == r_name);
    assign w_code_x10 = (r_code << 3) + (r_code << 1);
    assign w_flush_last = (CNT_W'(r_fidx) == r_cnt - 1'b1);

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_cnt        = r_cnt;
        n_code       = r_code;
        n_hex        = r_hex;
        n_dc         = r_dc;
        n_name       = r_name;
        n_fidx       = r_fidx;
        n_sidx       = r_sidx;
        n_byte       = r_byte;
        n_eot        = r_eot;
        n_tail       = r_tail;
        n_tail_emits = r_tail_emits;
        w_hwe        = 1'b0;
        w_hidx       = '0;
        w_hdata      = i_text_byte;
        w_hold       = 1'b0;
        o_push       = 1'b0;
        o_cmd        = '{kind: CMD_BYTE, data: '0, last: 1'b0};

        unique case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    n_byte = i_text_byte;
                    n_eot  = i_end_of_text;
                    unique case (r_mode)
                        M_TEXT: begin
                            if (i_text_byte == CH_AMP) begin
                                w_hwe  = 1'b1;
                                n_cnt  = CNT_W'(1);
                                n_mode = M_AMP;
                                n_name = '0;
                                if (i_end_of_text) begin
                                    n_state = F_FLUSH;
                                    n_fidx  = '0;
                                    n_tail  = 1'b0;
                                end
                            end else begin
                                o_push = 1'b1;
                                o_cmd  = '{kind: CMD_BYTE, data: CODE_W'(i_text_byte),
                                           last: 1'b1};
                            end
                        end
                        M_AMP: begin
                            if (i_text_byte == CH_HASH) begin
                                w_hold = 1'b1;
                                n_mode = M_HASH;
                            end else if (is_name_char(i_text_byte)) begin
                                w_hold = 1'b1;
                                n_mode = M_NAME;
                                n_name = {r_name[KEY_W-9:0], i_text_byte};
                            end
                        end
                        M_HASH: begin
                            if (i_text_byte == CH_LOW_X || i_text_byte == CH_UP_X) begin
                                w_hold = 1'b1;
                                n_hex  = 1'b1;
                                n_dc   = 3'd0;
                                n_code = '0;
                                n_mode = M_NUM;
                            end else if (i_text_byte >= 8'h30 && i_text_byte <= 8'h39) begin
                                w_hold = 1'b1;
                                n_hex  = 1'b0;
                                n_dc   = 3'd1;
                                n_code = CODE_W'(w_dig[3:0]);
                                n_mode = M_NUM;
                            end
                        end
                        M_NUM: begin
                            if (!w_dig[4] && r_dc < (r_hex ? 3'd6 : 3'd7)) begin
                                w_hold = 1'b1;
                                n_code = r_hex ? {r_code[CODE_W-5:0], w_dig[3:0]}
                                               : w_code_x10 + CODE_W'(w_dig[3:0]);
                                n_dc   = r_dc + 3'd1;
                            end else if (i_text_byte == CH_SEMI && r_dc != 3'd0) begin
                                o_push = 1'b1;
                                o_cmd  = '{kind: CMD_CODE, data: r_code, last: 1'b1};
                                n_mode = M_TEXT;
                                n_cnt  = '0;
                                n_code = '0;
                                n_hex  = 1'b0;
                                n_dc   = 3'd0;
                            end
                        end
                        M_NAME: begin
                            if (is_name_char(i_text_byte)) begin
                                if ((r_cnt - 1'b1) < CNT_W'(MAX_NAME_LEN)) begin
                                    w_hold = 1'b1;
                                    n_name = {r_name[KEY_W-9:0], i_text_byte};
                                end
                            end else if (i_text_byte == CH_SEMI) begin
                                if (w_name_ok && r_name == NGE_KEY) begin
                                    o_push = 1'b1;
                                    o_cmd  = '{kind: CMD_NGE, data: '0, last: 1'b1};
                                    n_mode = M_TEXT;
                                    n_cnt  = '0;
                                end else begin
                                    n_state = F_SEARCH;
                                    n_sidx  = '0;
                                end
                            end
                        end
                        default: ;
                    endcase

                    // reference broken by this byte
                    if (r_mode != M_TEXT && !w_hold && !o_push && n_state == F_IDLE) begin
                        n_state      = F_FLUSH;
                        n_fidx       = '0;
                        n_tail       = 1'b1;
                        n_tail_emits = (i_text_byte != CH_AMP) || i_end_of_text;
                    end

                    if (w_hold) begin
                        if (r_cnt < CNT_W'(HELD_DEPTH)) begin
                            w_hwe  = 1'b1;
                            w_hidx = r_cnt[IDX_W-1:0];
                            n_cnt  = r_cnt + 1'b1;
                        end
                        if (i_end_of_text) begin
                            n_state = F_FLUSH;
                            n_fidx  = '0;
                            n_tail  = 1'b0;
                        end
                    end
                end
            end
            F_FLUSH: begin
                if (!i_fifo_stat.full) begin
                    o_push = 1'b1;
                    o_cmd  = '{kind: CMD_BYTE, data: CODE_W'(r_held[r_fidx]),
                               last: w_flush_last && !(r_tail && r_tail_emits)};
                    if (w_flush_last) begin
                        n_mode  = M_TEXT;
                        n_cnt   = '0;
                        n_code  = '0;
                        n_hex   = 1'b0;
                        n_dc    = 3'd0;
                        n_state = r_tail ? F_PLAIN : F_IDLE;
                    end else begin
                        n_fidx = r_fidx + 1'b1;
                    end
                end
            end
            F_PLAIN: begin
                if (r_byte == CH_AMP) begin
                    w_hwe   = 1'b1;
                    w_hdata = r_byte;
                    n_cnt   = CNT_W'(1);
                    n_mode  = M_AMP;
                    n_name  = '0;
                    n_fidx  = '0;
                    n_tail  = 1'b0;
                    n_state = r_eot ? F_FLUSH : F_IDLE;
                end else if (!i_fifo_stat.full) begin
                    o_push  = 1'b1;
                    o_cmd   = '{kind: CMD_BYTE, data: CODE_W'(r_byte), last: 1'b1};
                    n_state = F_IDLE;
                end
            end
            F_SEARCH: begin
                if (w_hit) begin
                    if (!i_fifo_stat.full) begin
                        o_push  = 1'b1;
                        o_cmd   = '{kind: CMD_CODE, data: CODE_W'(NAME_ROM[r_sidx].point),
                                    last: 1'b1};
                        n_mode  = M_TEXT;
                        n_cnt   = '0;
                        n_state = F_IDLE;
                    end
                end else if (r_sidx == ROM_IDX_W'(SEARCH_N - 1)) begin
                    n_state      = F_FLUSH;
                    n_fidx       = '0;
                    n_tail       = 1'b1;
                    n_tail_emits = (r_byte != CH_AMP) || r_eot;
                end else begin
                    n_sidx = r_sidx + 1'b1;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_hwe) begin
            r_held[w_hidx] <= w_hdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_mode       <= M_TEXT;
            r_cnt        <= '0;
            r_code       <= '0;
            r_hex        <= 1'b0;
            r_dc         <= 3'd0;
            r_tail       <= 1'b0;
            r_tail_emits <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_cnt        <= n_cnt;
            r_code       <= n_code;
            r_hex        <= n_hex;
            r_dc         <= n_dc;
            r_tail       <= n_tail;
            r_tail_emits <= n_tail_emits;
        end
    end

    always_ff @(posedge i_clk) begin
        r_name <= n_name;
        r_fidx <= n_fidx;
        r_sidx <= n_sidx;
        r_byte <= n_byte;
        r_eot  <= n_eot;
    end

endmodule

/* rtl/chrd_cmd_fifo.sv */
// command queue between scanner and byte emitter
module chrd_cmd_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  chrd_pkg::t_cmd       i_cmd,
    input  logic                 i_pop,
    output chrd_pkg::t_cmd       o_cmd,
    output chrd_pkg::t_fifo_stat o_stat
);
    import chrd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_cmd        = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

endmodule

/* rtl/chrd_back.sv */
// back end: utf-8 expansion and output register
module chrd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  chrd_pkg::t_cmd       i_cmd,
    input  chrd_pkg::t_fifo_stat i_fifo_stat,
    output logic                 o_pop,
    output logic [7:0]           o_out_byte,
    output logic                 o_last_of_run,
    output logic                 o_valid,
    input  logic                 i_ready
);
    import chrd_pkg::*;

    localparam logic [4:0][7:0] NGE_BYTES = {8'hB8, 8'hCC, 8'hA7, 8'h89, 8'hE2};

    typedef struct packed {
        logic [4:0][7:0] bytes;
        logic [2:0]      n;
    } t_seq;

    function automatic t_seq expand(input t_cmd c);
        t_seq        s;
        logic [20:0] cp;
        s.bytes = '0;
        s.n     = 3'd1;
        cp      = c.data[20:0];
        if (c.data == '0 || (c.data >= CODE_W'(24'hD800) && c.data <= CODE_W'(24'hDFFF)) ||
            c.data > CODE_W'(24'h10FFFF)) begin
            cp = 21'hFFFD;
        end
        unique case (c.kind)
            CMD_BYTE: begin
                s.bytes[0] = c.data[7:0];
            end
            CMD_NGE: begin
                s.bytes = NGE_BYTES;
                s.n     = 3'd5;
            end
            CMD_CODE: begin
                if (cp < 21'h80) begin
                    s.bytes[0] = {1'b0, cp[6:0]};
                end else if (cp < 21'h800) begin
                    s.bytes[0] = 8'hC0 | {3'b0, cp[10:6]};
                    s.bytes[1] = 8'h80 | {2'b0, cp[5:0]};
                    s.n        = 3'd2;
                end else if (cp < 21'h10000) begin
                    s.bytes[0] = 8'hE0 | {4'b0, cp[15:12]};
                    s.bytes[1] = 8'h80 | {2'b0, cp[11:6]};
                    s.bytes[2] = 8'h80 | {2'b0, cp[5:0]};
                    s.n        = 3'd3;
                end else begin
                    s.bytes[0] = 8'hF0 | {5'b0, cp[20:18]};
                    s.bytes[1] = 8'h80 | {2'b0, cp[17:12]};
                    s.bytes[2] = 8'h80 | {2'b0, cp[11:6]};
                    s.bytes[3] = 8'h80 | {2'b0, cp[5:0]};
                    s.n        = 3'd4;
                end
            end
            default: s.bytes[0] = c.data[7:0];
        endcase
        return s;
    endfunction

    logic            r_act;
    logic [4:0][7:0] r_seq;
    logic [2:0]      r_n, r_i;
    logic            r_last;
    logic            r_ov;
    logic [7:0]      r_ob;
    logic            r_ol;
    logic            w_out_free;
    logic            w_final;
    t_seq            w_exp;

    assign o_pop         = !r_act && !i_fifo_stat.empty;
    assign w_out_free    = !r_ov || i_ready;
    assign w_final       = (r_i == r_n - 3'd1);
    assign w_exp         = expand(i_cmd);
    assign o_valid       = r_ov;
    assign o_out_byte    = r_ob;
    assign o_last_of_run = r_ol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_act <= 1'b1;
            end else if (r_act && w_out_free && w_final) begin
                r_act <= 1'b0;
            end
            if (r_act && w_out_free) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_seq  <= w_exp.bytes;
            r_n    <= w_exp.n;
            r_i    <= 3'd0;
            r_last <= i_cmd.last;
        end else if (r_act && w_out_free) begin
            r_i <= r_i + 3'd1;
        end
        if (r_act && w_out_free) begin
            r_ob <= r_seq[r_i];
            r_ol <= r_last && w_final;
        end
    end

endmodule

/* rtl/char_reference_decoder.sv */
// top level of the character reference decoder
//
//  channel   valid        ready        payload
//  input     i_in_valid   o_in_ready   i_text_byte, i_end_of_text
//  output    o_out_valid  i_out_ready  o_out_byte, o_last_of_run
//
// plain bytes and numeric references pass the scanner without a name search
// a named reference searches the name table one entry per cycle (up to 247)
// a broken reference replays its held bytes at one byte per cycle, stalling
// on a full queue; utf-8 expansion runs behind a four-entry command queue:
// a command loads after the last ends, then emits one byte per cycle unless
// output stalls; input stalls while the scanner is busy or the queue is full
// synchronous active-low reset; no clearing pass
`include "char_reference_decoder_assert.svh"

module char_reference_decoder #(
    parameter int MAX_NAME_LEN   = 24,
    parameter int NAME_ROM_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_out_valid,
    input  logic       i_out_ready
);
    import chrd_pkg::*;

    t_cmd       w_push_cmd, w_head_cmd;
    logic       w_push, w_pop;
    t_fifo_stat w_fifo_stat;

    chrd_front #(
        .MAX_NAME_LEN   (MAX_NAME_LEN),
        .NAME_ROM_DEPTH (NAME_ROM_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_fifo_stat   (w_fifo_stat),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    chrd_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_stat  (w_fifo_stat)
    );

    chrd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_head_cmd),
        .i_fifo_stat   (w_fifo_stat),
        .o_pop         (w_pop),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready)
    );

    `CHRD_ASSERT_NOW(a_push_not_full, w_push, !w_fifo_stat.full, "push into full queue")
    `CHRD_ASSERT_NOW(a_pop_not_empty, w_pop, !w_fifo_stat.empty, "pop from empty queue")
    `CHRD_ASSERT_NEXT(a_pop_frees, w_pop, !w_fifo_stat.full, "queue full after pop")
    `CHRD_ASSERT_NOW(a_accept_room, i_in_valid && o_in_ready, !w_fifo_stat.full, "request taken with no queue room")

endmodule
